### design/rwt_pkg.sv
package rwt_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CAP_W   = 11;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TAG_W   = 32;

  localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   slot_index;
    logic [STAMP_W-1:0] timestamp;
    logic [TAG_W-1:0]   payload_tag;
  } in_t;

  typedef struct packed {
    logic               status;
    logic               in_window;
    logic [STAMP_W-1:0] stored_stamp;
    logic [TAG_W-1:0]   stored_tag;
    logic [IDX_W-1:0]   head_pos;
    logic [IDX_W-1:0]   tail_pos;
    logic [CAP_W-1:0]   fill_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_valid;
  } ctl_status_t;

endpackage

### design/rwt_ctrl.sv
module rwt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  rwt_pkg::ctl_status_t status,
  output rwt_pkg::ctl_cmd_t    cmd
);
  import rwt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // The result register is free, or its transfer completes this cycle.
        in_ready = !status.out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

### design/rwt_datapath.sv
module rwt_datapath #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rwt_pkg::CAP_W-1:0] cfg_wdata,
  input  rwt_pkg::in_t              in_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output rwt_pkg::out_t             out_data,
  input  rwt_pkg::ctl_cmd_t         cmd,
  output rwt_pkg::ctl_status_t      status
);
  import rwt_pkg::*;

  localparam int unsigned AW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = (SLOT_COUNT > 2047) ? $clog2(SLOT_COUNT + 1) : CAP_W;
  localparam int unsigned MW = STAMP_W + TAG_W;

  logic [MW-1:0] mem [SLOT_COUNT];
  logic [MW-1:0] rd_data;
  logic [AW-1:0] clr_addr;
  in_t           req;

  logic [CW-1:0] capacity;
  logic [CW-1:0] head;
  logic [CW-1:0] tail;
  logic [CW-1:0] fill;
  logic [CW-1:0] head_next;
  logic [CW-1:0] tail_next;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] cfg_val;
  logic [CW-1:0] cap_clamped;

  logic [CW-1:0]    idx;
  logic [CW-1:0]    idx_inc;
  logic [CW-1:0]    fwd_dist;
  logic [CW:0]      grown;
  logic [CW-1:0]    fill_ends;
  logic             valid_idx;
  logic             newer;
  logic             in_win_pre;
  logic             far;
  logic             wr_en;
  logic             ok;
  logic [STAMP_W-1:0] stamp_out;
  logic [TAG_W-1:0]   tag_out;

  function automatic logic in_win(input logic [CW-1:0] i, input logic [CW-1:0] h,
                                  input logic [CW-1:0] t, input logic [CW-1:0] f,
                                  input logic [CW-1:0] c);
    logic r;
    if (f == '0) begin
      r = 1'b0;
    end else if (h > t) begin
      r = !(i >= t && i < h);
    end else if (h < t) begin
      r = i >= h && i < t;
    end else begin
      r = f == c;
    end
    return r;
  endfunction

  assign status.clear_last = clr_addr == AW'(SLOT_COUNT - 1);
  assign status.out_valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Slot store: the read address follows the input payload so that the
  // data is ready in the cycle after the transfer.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[AW'(req.slot_index)] <= {req.timestamp, req.payload_tag};
    end
    rd_data <= mem[AW'(in_data.slot_index)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
  end

  always_comb begin
    idx        = CW'(req.slot_index);
    valid_idx  = idx < capacity;
    newer      = req.timestamp > rd_data[MW-1:TAG_W];
    in_win_pre = in_win(idx, head, tail, fill, capacity);
    idx_inc    = idx + CW'(1);
    // The tail always stays below the capacity, so this cannot wrap.
    fwd_dist   = (idx >= tail) ? (idx - tail) : ((capacity - tail) + idx);
    far        = {fwd_dist, 1'b0} > {1'b0, capacity};
    grown      = (CW+1)'(fill) + (CW+1)'(fwd_dist) + (CW+1)'(1);
    if (idx > tail) begin
      fill_ends = tail + (capacity - idx);
    end else if (idx < tail) begin
      fill_ends = tail - idx;
    end else begin
      fill_ends = '0;
    end

    head_next = head;
    tail_next = tail;
    fill_next = fill;
    wr_en     = 1'b0;
    ok        = 1'b0;
    if (valid_idx) begin
      unique case (req.cmd)
        CMD_RECEIVE: begin
          if (newer) begin
            wr_en = cmd.exec;
            ok    = in_win_pre || !far;
            if (!in_win_pre && !far) begin
              fill_next = (grown > {1'b0, capacity}) ? capacity : grown[CW-1:0];
              tail_next = (idx_inc == capacity) ? '0 : idx_inc;
            end
          end
        end
        CMD_ADVANCE: begin
          ok = 1'b1;
          if (idx == head) begin
            ok = 1'b1;
          end else if (idx == tail) begin
            head_next = tail;
            fill_next = '0;
          end else if (head > tail) begin
            if (idx > tail && idx < head) begin
              ok = 1'b0;
            end else begin
              head_next = idx;
              fill_next = fill_ends;
            end
          end else if (head < tail) begin
            if (idx < head || idx > tail) begin
              ok = 1'b0;
            end else begin
              head_next = idx;
              fill_next = fill_ends;
            end
          end else if (fill == capacity) begin
            head_next = idx;
            fill_next = fill_ends;
          end
        end
        CMD_READ: begin
          ok = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end

    if (!valid_idx) begin
      stamp_out = '0;
      tag_out   = '0;
    end else if (wr_en) begin
      stamp_out = req.timestamp;
      tag_out   = req.payload_tag;
    end else begin
      stamp_out = rd_data[MW-1:TAG_W];
      tag_out   = rd_data[TAG_W-1:0];
    end
  end

  always_comb begin
    cfg_val = CW'(cfg_wdata);
    if (cfg_val == '0) begin
      cap_clamped = CW'(1);
    end else if (32'(cfg_val) > SLOT_COUNT) begin
      cap_clamped = CW'(SLOT_COUNT);
    end else begin
      cap_clamped = cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(SLOT_COUNT);
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
    end else if (cfg_we) begin
      capacity <= cap_clamped;
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data.status       <= !ok;
      out_data.in_window    <= valid_idx &&
                               in_win(idx, head_next, tail_next, fill_next, capacity);
      out_data.stored_stamp <= stamp_out;
      out_data.stored_tag   <= tag_out;
      out_data.head_pos     <= head_next[IDX_W-1:0];
      out_data.tail_pos     <= tail_next[IDX_W-1:0];
      out_data.fill_count   <= fill_next[CAP_W-1:0];
    end
  end

endmodule

### design/receive_window_tracker_unit.sv
// A result is registered in the execute state that follows its input transfer.
// No new input is taken until that state is done: the slot memory is read into
// a register, then compared and written back to the same slot.
// Reset (synchronous, active high) clears head, tail and fill, sets capacity to
// SLOT_COUNT, then sweeps every slot of the memory to zero with in_ready low;
// configuration writes are taken during the sweep.
module receive_window_tracker_unit #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rwt_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rwt_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rwt_pkg::out_t             out_data
);
  import rwt_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  rwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rwt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
